@@ rtl/timeout_slot_table_defines.svh @@
// ---------------------------------------------------------------------------
// Timeout slot table assertion macros
// Concurrent assertion helpers used by the datapath (tst_dp).
// ---------------------------------------------------------------------------
`ifndef TIMEOUT_SLOT_TABLE_DEFINES_SVH
`define TIMEOUT_SLOT_TABLE_DEFINES_SVH
`ifndef ASSERT_OFF
`define TST_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define TST_ASSERT_ALWAYS(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define TST_ASSERT(lbl, clk, rst, prop, msg)
`define TST_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif
`endif

@@ rtl/tst_pkg.sv @@
// ---------------------------------------------------------------------------
// Timeout slot table package
// Field widths, codes, state type and controller/datapath interface structs.
// ---------------------------------------------------------------------------
package tst_pkg;

   localparam int NUM_SLOTS_DEF = 16;
   localparam int SLOT_W        = 4;
   localparam int MAX_SCAN      = 16;
   localparam int TIME_W        = 48;
   localparam int DELAY_W       = 32;
   localparam int TAG_W         = 16;
   localparam int REM_W         = 32;
   localparam int ACTION_W      = 2;
   localparam int KIND_W        = 2;

   typedef enum logic [ACTION_W-1:0] {
      ACT_SCHEDULE = 2'd0,
      ACT_CANCEL   = 2'd1,
      ACT_CHECK    = 2'd2,
      ACT_QUERY    = 2'd3
   } action_type;

   typedef enum logic [KIND_W-1:0] {
      KIND_ACK  = 2'd0,
      KIND_DUE  = 2'd1,
      KIND_LEFT = 2'd2
   } kind_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_EXEC,
      ST_SCAN,
      ST_FINISH
   } state_type;

   typedef struct packed {
      logic load;
      logic exec;
      logic scan;
      logic finish;
   } cmd_type;

   typedef struct packed {
      logic new_check;
      logic out_free;
      logic scan_blocked;
      logic scan_last;
   } sts_type;

endpackage

@@ rtl/tst_ctrl.sv @@
// ---------------------------------------------------------------------------
// Timeout slot table controller
// Sequences one item at a time: single-result actions or a slot scan.
// ---------------------------------------------------------------------------
module tst_ctrl
   import tst_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  sts_type sts,
   output cmd_type cmd
);

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               state_in = sts.new_check ? ST_SCAN : ST_EXEC;
            end
         end
         ST_EXEC: begin
            if (sts.out_free) begin
               state_in = ST_IDLE;
            end
         end
         ST_SCAN: begin
            if (!sts.scan_blocked && sts.scan_last) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (sts.out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      cmd       = '0;
      req_stall = 1'b1;
      case (state_ff)
         ST_IDLE: begin
            req_stall = 1'b0;
            cmd.load  = req_valid;
         end
         ST_EXEC:   cmd.exec   = sts.out_free;
         ST_SCAN:   cmd.scan   = 1'b1;
         ST_FINISH: cmd.finish = sts.out_free;
         default:   cmd        = '0;
      endcase
   end

endmodule

@@ rtl/tst_dp.sv @@
// ---------------------------------------------------------------------------
// Timeout slot table datapath
// Slot storage, deadline arithmetic, scan counter and result register.
// ---------------------------------------------------------------------------
`include "timeout_slot_table_defines.svh"

module tst_dp
   import tst_pkg::*;
#(
   parameter int NUM_SLOTS = NUM_SLOTS_DEF
) (
   input  logic                clock,
   input  logic                reset,
   input  cmd_type             cmd,
   output sts_type             sts,
   input  logic [ACTION_W-1:0] req_action,
   input  logic [TIME_W-1:0]   req_now_us,
   input  logic [SLOT_W-1:0]   req_slot,
   input  logic [DELAY_W-1:0]  req_delay_us,
   input  logic [TAG_W-1:0]    req_tag,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic [KIND_W-1:0]   rsp_result_kind,
   output logic                rsp_status,
   output logic [SLOT_W-1:0]   rsp_due_slot,
   output logic [TAG_W-1:0]    rsp_due_tag,
   output logic [REM_W-1:0]    rsp_remaining_us,
   output logic                rsp_last
);

   localparam int SCAN = (NUM_SLOTS < MAX_SCAN) ? NUM_SLOTS : MAX_SCAN;
   localparam int IW   = (SCAN > 1) ? $clog2(SCAN) : 1;

   action_type               act_ff;
   logic [TIME_W-1:0]        now_ff;
   logic [SLOT_W-1:0]        slot_ff;
   logic [DELAY_W-1:0]       delay_ff;
   logic [TAG_W-1:0]         tag_ff;

   logic [IW-1:0]            cnt_ff;
   logic                     pend_valid_ff;
   logic [SLOT_W-1:0]        pend_slot_ff;
   logic [TAG_W-1:0]         pend_tag_ff;

   logic [SCAN-1:0]          active_ff;
   logic [TIME_W-1:0]        deadline_ff [SCAN];
   logic [TAG_W-1:0]         stag_ff     [SCAN];

   logic                     rsp_valid_ff;
   kind_type                 rsp_kind_ff;
   logic                     rsp_status_ff;
   logic [SLOT_W-1:0]        rsp_slot_ff;
   logic [TAG_W-1:0]         rsp_tag_ff;
   logic [REM_W-1:0]         rsp_rem_ff;
   logic                     rsp_last_ff;

   logic                     out_free;
   logic                     in_range;
   logic [IW-1:0]            rd_idx;
   logic                     rd_active;
   logic [TIME_W-1:0]        rd_deadline;
   logic [TAG_W-1:0]         rd_tag;
   logic [TIME_W-1:0]        diff;
   logic [TIME_W-1:0]        left;
   logic                     passed;
   logic [REM_W-1:0]         rem_sat;
   logic                     hit;
   logic                     scan_blocked;
   logic                     scan_last;

   logic                     emit;
   kind_type                 e_kind;
   logic                     e_status;
   logic [SLOT_W-1:0]        e_slot;
   logic [TAG_W-1:0]         e_tag;
   logic [REM_W-1:0]         e_rem;
   logic                     e_last;

   assign out_free     = !rsp_valid_ff || !rsp_stall;
   assign in_range     = {1'b0, slot_ff} < (SLOT_W+1)'(SCAN);
   assign rd_idx       = cmd.scan ? cnt_ff : slot_ff[IW-1:0];
   assign rd_active    = active_ff[rd_idx];
   assign rd_deadline  = deadline_ff[rd_idx];
   assign rd_tag       = stag_ff[rd_idx];
   // wrapping compare: passed when (now - deadline) lies in the lower half
   assign diff         = now_ff - rd_deadline;
   assign passed       = !diff[TIME_W-1];
   assign left         = rd_deadline - now_ff;
   assign rem_sat      = (|left[TIME_W-1:REM_W]) ? '1 : left[REM_W-1:0];
   assign hit          = rd_active && passed;
   assign scan_blocked = hit && pend_valid_ff && !out_free;
   assign scan_last    = cnt_ff == IW'(SCAN - 1);

   assign sts.new_check    = req_action == ACT_CHECK;
   assign sts.out_free     = out_free;
   assign sts.scan_blocked = scan_blocked;
   assign sts.scan_last    = scan_last;

   always_comb begin
      emit     = 1'b0;
      e_kind   = KIND_ACK;
      e_status = 1'b0;
      e_slot   = '0;
      e_tag    = '0;
      e_rem    = '0;
      e_last   = 1'b0;
      if (cmd.exec) begin
         emit   = 1'b1;
         e_slot = slot_ff;
         e_last = 1'b1;
         case (act_ff)
            ACT_SCHEDULE: e_status = !in_range;
            ACT_CANCEL:   e_status = !(in_range && rd_active);
            ACT_QUERY: begin
               e_kind = KIND_LEFT;
               if (in_range && rd_active) begin
                  e_tag = rd_tag;
                  e_rem = passed ? '0 : rem_sat;
               end else begin
                  e_status = 1'b1;
               end
            end
            default: e_status = 1'b1;
         endcase
      end else if (cmd.scan) begin
         if (hit && pend_valid_ff && out_free) begin
            emit   = 1'b1;
            e_kind = KIND_DUE;
            e_slot = pend_slot_ff;
            e_tag  = pend_tag_ff;
         end
      end else if (cmd.finish) begin
         emit   = 1'b1;
         e_kind = KIND_DUE;
         e_last = 1'b1;
         if (pend_valid_ff) begin
            e_slot = pend_slot_ff;
            e_tag  = pend_tag_ff;
         end else begin
            e_status = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         act_ff   <= action_type'(req_action);
         now_ff   <= req_now_us;
         slot_ff  <= req_slot;
         delay_ff <= req_delay_us;
         tag_ff   <= req_tag;
      end
      if (cmd.exec && in_range && act_ff == ACT_SCHEDULE) begin
         deadline_ff[slot_ff[IW-1:0]] <= now_ff + TIME_W'(delay_ff);
         stag_ff[slot_ff[IW-1:0]]     <= tag_ff;
      end
      if (cmd.scan && !scan_blocked && hit) begin
         pend_slot_ff <= SLOT_W'(cnt_ff);
         pend_tag_ff  <= rd_tag;
      end
      if (emit) begin
         rsp_kind_ff   <= e_kind;
         rsp_status_ff <= e_status;
         rsp_slot_ff   <= e_slot;
         rsp_tag_ff    <= e_tag;
         rsp_rem_ff    <= e_rem;
         rsp_last_ff   <= e_last;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff     <= '0;
         cnt_ff        <= '0;
         pend_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         if (cmd.exec && in_range) begin
            if (act_ff == ACT_SCHEDULE) begin
               active_ff[slot_ff[IW-1:0]] <= 1'b1;
            end else if (act_ff == ACT_CANCEL) begin
               active_ff[slot_ff[IW-1:0]] <= 1'b0;
            end
         end
         if (cmd.load) begin
            cnt_ff        <= '0;
            pend_valid_ff <= 1'b0;
         end else if (cmd.scan && !scan_blocked) begin
            cnt_ff <= cnt_ff + 1'b1;
            if (hit) begin
               pend_valid_ff <= 1'b1;
            end
         end
         if (emit) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_result_kind  = rsp_kind_ff;
   assign rsp_status       = rsp_status_ff;
   assign rsp_due_slot     = rsp_slot_ff;
   assign rsp_due_tag      = rsp_tag_ff;
   assign rsp_remaining_us = rsp_rem_ff;
   assign rsp_last         = rsp_last_ff;

   `TST_ASSERT(a_cmd_onehot, clock, reset, $onehot0({cmd.load, cmd.exec, cmd.scan, cmd.finish}), "more than one command active")
   `TST_ASSERT(a_load_clears, clock, reset, cmd.load |=> (!pend_valid_ff && cnt_ff == '0), "scan state not cleared on load")
   `TST_ASSERT(a_mid_is_due, clock, reset, (rsp_valid_ff && !rsp_last_ff) |-> (rsp_kind_ff == KIND_DUE), "non-final item that is not a due result")
   `TST_ASSERT(a_emit_free, clock, reset, emit |-> out_free, "result written over a waiting item")

endmodule

@@ rtl/timeout_slot_table.sv @@
// ---------------------------------------------------------------------------
// Timeout slot table
// Table of timeout slots with schedule, cancel, due check and time-left query.
// ---------------------------------------------------------------------------
// Items are handled one at a time. Schedule, cancel and query are loaded
// and then executed once the output register is free. Check walks
// min(NUM_SLOTS,16) slots one per cycle, but pauses while a new due slot
// meets a pending one and the output register is full; a due slot is held
// in a pending register so the final result carries last. A new item may
// be accepted while the previous result still waits in the output register.
module timeout_slot_table
   import tst_pkg::*;
#(
   parameter int NUM_SLOTS = NUM_SLOTS_DEF
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  logic [ACTION_W-1:0] req_action,
   input  logic [TIME_W-1:0]   req_now_us,
   input  logic [SLOT_W-1:0]   req_slot,
   input  logic [DELAY_W-1:0]  req_delay_us,
   input  logic [TAG_W-1:0]    req_tag,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic [KIND_W-1:0]   rsp_result_kind,
   output logic                rsp_status,
   output logic [SLOT_W-1:0]   rsp_due_slot,
   output logic [TAG_W-1:0]    rsp_due_tag,
   output logic [REM_W-1:0]    rsp_remaining_us,
   output logic                rsp_last
);

   cmd_type cmd;
   sts_type sts;

   tst_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .sts       (sts),
      .cmd       (cmd)
   );

   tst_dp #(
      .NUM_SLOTS (NUM_SLOTS)
   ) u_dp (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .sts              (sts),
      .req_action       (req_action),
      .req_now_us       (req_now_us),
      .req_slot         (req_slot),
      .req_delay_us     (req_delay_us),
      .req_tag          (req_tag),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_result_kind  (rsp_result_kind),
      .rsp_status       (rsp_status),
      .rsp_due_slot     (rsp_due_slot),
      .rsp_due_tag      (rsp_due_tag),
      .rsp_remaining_us (rsp_remaining_us),
      .rsp_last         (rsp_last)
   );

endmodule
